// File: rtl/core/cdec_pkg.sv
// Package with shared constants, types and a helper function of the chunked transfer decoder.
`timescale 1ns / 1ps
package cdec_pkg;

  localparam int unsigned MaxSizeDigits = 8;
  localparam int unsigned DigitCntW     = $clog2(MaxSizeDigits + 2);
  localparam int unsigned SizeW         = 32;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  // Size values above this limit saturate instead of shifting in another digit.
  localparam logic [SizeW-1:0] SizeShiftLimit = 32'h0FFF_FFFF;

  typedef enum logic [1:0] {
    LINE_BODY      = 2'd0,
    LINE_EXPECT_CR = 2'd1,
    LINE_EXPECT_LF = 2'd2
  } line_step_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_has_data;
    logic       error_raised;
    logic       raw_mode;
  } cdec_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      // Letters a-f and A-F share the low nibble 1..6.
      r.value = c[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/cdec_if.sv
// Handshake interfaces for the input byte channel and the result channel.
`timescale 1ns / 1ps
interface cdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface cdec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_has_data;
  logic       error_raised;
  logic       raw_mode;

  modport source (output valid, output out_byte, output out_has_data,
                  output error_raised, output raw_mode, input ready);
  modport sink   (input valid, input out_byte, input out_has_data,
                  input error_raised, input raw_mode, output ready);
endinterface

// File: rtl/core/chunked_transfer_decoder_core.sv
// Top level of the chunked transfer decoder.
`timescale 1ns / 1ps
// Removes HTTP chunked framing from a byte stream: each accepted byte is
// classified in the same cycle by the framing state machine, and any result
// (a payload byte, a raw pass-through byte after a framing error, or the
// error indication itself) enters a two-entry result queue that feeds the
// output channel. One byte is accepted per clock while the queue has room, so
// with a sink that keeps ready high the block sustains one transaction per
// cycle, and each result appears in the cycle after its byte is accepted.
// Bytes that only carry framing produce no result. After a framing error
// every later byte is passed through with raw_mode set.
module chunked_transfer_decoder_core (
  input  logic clk_i,
  input  logic rst_ni,
  cdec_in_if.sink    in_i,
  cdec_out_if.source out_o
);
  import cdec_pkg::*;

  logic         step;
  logic         res_valid;
  cdec_result_t res;
  logic         queue_full;
  cdec_result_t head;

  assign in_i.ready = !queue_full;
  assign step       = in_i.valid && !queue_full;

  cdec_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_i.in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cdec_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (queue_full),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .data_o      (head)
  );

  assign out_o.out_byte     = head.out_byte;
  assign out_o.out_has_data = head.out_has_data;
  assign out_o.error_raised = head.error_raised;
  assign out_o.raw_mode     = head.raw_mode;

endmodule

// File: rtl/core/cdec_parser.sv
// Front end: framing state machine that classifies each accepted byte.
`timescale 1ns / 1ps
module cdec_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output logic                  res_valid_o,
  output cdec_pkg::cdec_result_t res_o
);
  import cdec_pkg::*;

  logic                 in_payload_q, in_payload_d;
  line_step_e           line_step_q, line_step_d;
  logic [SizeW-1:0]     size_value_q, size_value_d;
  logic [DigitCntW-1:0] digit_cnt_q, digit_cnt_d;
  logic                 bad_digit_q, bad_digit_d;
  logic [SizeW-1:0]     bytes_left_q, bytes_left_d;
  logic                 error_q, error_d;

  hex_digit_t hex;
  logic       overlong;

  assign hex      = hex_decode(byte_i);
  assign overlong = digit_cnt_q > DigitCntW'(MaxSizeDigits);

  // Result of the current transaction.
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (error_q) begin
        res_o.out_byte     = byte_i;
        res_o.out_has_data = 1'b1;
        res_o.raw_mode     = 1'b1;
      end else if (!in_payload_q) begin
        unique case (line_step_q)
          LINE_BODY: begin
            // An overlong size line passes the offending byte through raw.
            if (overlong) begin
              res_o.out_byte     = byte_i;
              res_o.out_has_data = 1'b1;
              res_o.error_raised = 1'b1;
              res_o.raw_mode     = 1'b1;
            end
          end
          LINE_EXPECT_CR: res_o.error_raised = (byte_i != ChCr);
          LINE_EXPECT_LF: begin
            res_o.error_raised = (byte_i != ChLf) || (digit_cnt_q == '0) || bad_digit_q;
          end
          default: res_o = '0;
        endcase
      end else begin
        unique case (line_step_q)
          LINE_BODY: begin
            if (bytes_left_q == '0) begin
              res_o.error_raised = (byte_i != ChCr);
            end else begin
              res_o.out_byte     = byte_i;
              res_o.out_has_data = 1'b1;
            end
          end
          LINE_EXPECT_CR: res_o.error_raised = (byte_i != ChCr);
          LINE_EXPECT_LF: res_o.error_raised = (byte_i != ChLf);
          default: res_o = '0;
        endcase
      end
      res_valid_o = res_o.out_has_data || res_o.error_raised;
    end
  end

  // Next state.
  always_comb begin
    in_payload_d = in_payload_q;
    line_step_d  = line_step_q;
    size_value_d = size_value_q;
    digit_cnt_d  = digit_cnt_q;
    bad_digit_d  = bad_digit_q;
    bytes_left_d = bytes_left_q;
    error_d      = error_q || res_o.error_raised;
    if (step_i && !error_q && !res_o.error_raised) begin
      if (!in_payload_q) begin
        unique case (line_step_q)
          LINE_BODY: begin
            if (byte_i == ChCr) begin
              line_step_d = LINE_EXPECT_LF;
            end else begin
              digit_cnt_d = digit_cnt_q + DigitCntW'(1);
              if (!hex.ok) begin
                bad_digit_d = 1'b1;
              end else if (size_value_q > SizeShiftLimit) begin
                size_value_d = '1;
              end else begin
                size_value_d = {size_value_q[SizeW-5:0], hex.value};
              end
            end
          end
          LINE_EXPECT_CR: line_step_d = LINE_EXPECT_LF;
          LINE_EXPECT_LF: begin
            in_payload_d = 1'b1;
            bytes_left_d = size_value_q;
            line_step_d  = (size_value_q == '0) ? LINE_EXPECT_CR : LINE_BODY;
          end
          default: line_step_d = line_step_q;
        endcase
      end else begin
        unique case (line_step_q)
          LINE_BODY: begin
            if (bytes_left_q == '0) begin
              line_step_d = LINE_EXPECT_LF;
            end else begin
              bytes_left_d = bytes_left_q - SizeW'(1);
              if (bytes_left_q == SizeW'(1)) line_step_d = LINE_EXPECT_CR;
            end
          end
          LINE_EXPECT_CR: line_step_d = LINE_EXPECT_LF;
          LINE_EXPECT_LF: begin
            line_step_d  = LINE_BODY;
            in_payload_d = 1'b0;
          end
          default: line_step_d = line_step_q;
        endcase
      end
    end
    // The size line collector restarts after every LF seen on a size line or closing line.
    if (step_i && !error_q && line_step_q == LINE_EXPECT_LF &&
        (!in_payload_q || !res_o.error_raised)) begin
      size_value_d = '0;
      digit_cnt_d  = '0;
      bad_digit_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      line_step_q  <= LINE_BODY;
      size_value_q <= '0;
      digit_cnt_q  <= '0;
      bad_digit_q  <= 1'b0;
      bytes_left_q <= '0;
      error_q      <= 1'b0;
    end else begin
      in_payload_q <= in_payload_d;
      line_step_q  <= line_step_d;
      size_value_q <= size_value_d;
      digit_cnt_q  <= digit_cnt_d;
      bad_digit_q  <= bad_digit_d;
      bytes_left_q <= bytes_left_d;
      error_q      <= error_d;
    end
  end

endmodule

// File: rtl/core/cdec_queue.sv
// Back end: short result queue that drives the output channel.
`timescale 1ns / 1ps
module cdec_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  cdec_pkg::cdec_result_t push_data_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output cdec_pkg::cdec_result_t data_o
);
  import cdec_pkg::*;

  cdec_result_t         mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o  = count_q == QueueCntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = valid_o && ready_i;

  function automatic logic [QueuePtrW-1:0] ptr_next(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + QueuePtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QueueCntW'(1);
        2'b01:   count_q <= count_q - QueueCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: test/cdec_checker.sv
// Checker that predicts the decoder's results from the input channel and compares the output channel.
`timescale 1ns / 1ps
module cdec_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdec_in_if         in_mon,
  cdec_out_if        out_mon,
  output int         fail_count_o,
  output int         pending_o,
  output int         bytes_o,
  output int         payload_o,
  output int         raw_o,
  output int         framing_errors_o
);
  import cdec_pkg::*;

  // Only the first few mismatches are printed so that a broken block cannot flood the log.
  localparam int unsigned PrintCap = 30;

  logic                 parsing_payload;
  line_step_e           line_step;
  logic [SizeW-1:0]     size_acc;
  logic [DigitCntW-1:0] digits_taken;
  logic                 bad_char_seen;
  logic [SizeW-1:0]     bytes_remaining;
  logic                 framing_broken;

  cdec_result_t decoded_queue[$];

  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] nib);
    logic ok;
    ok  = 1'b1;
    nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      nib = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      nib = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      nib = 4'(c - 8'h57);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count_o < PrintCap) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    cdec_result_t r;
    logic [3:0]   nib;
    r = '0;
    if (framing_broken) begin
      r.out_byte     = b;
      r.out_has_data = 1'b1;
      r.raw_mode     = 1'b1;
    end else if (!parsing_payload) begin
      case (line_step)
        LINE_BODY: begin
          if (int'(digits_taken) > MaxSizeDigits) begin
            // An overlong size line: the byte that trips it is passed through raw.
            framing_broken = 1'b1;
            r.out_byte     = b;
            r.out_has_data = 1'b1;
            r.error_raised = 1'b1;
            r.raw_mode     = 1'b1;
          end else if (b == ChCr) begin
            line_step = LINE_EXPECT_LF;
          end else begin
            digits_taken++;
            if (!hex_nibble(b, nib)) begin
              bad_char_seen = 1'b1;
            end else if (size_acc > SizeShiftLimit) begin
              size_acc = '1;
            end else begin
              size_acc = {size_acc[SizeW-5:0], nib};
            end
          end
        end
        LINE_EXPECT_CR: begin
          if (b != ChCr) begin
            framing_broken = 1'b1;
            r.error_raised = 1'b1;
          end else begin
            line_step = LINE_EXPECT_LF;
          end
        end
        default: begin
          if (b != ChLf || digits_taken == '0 || bad_char_seen) begin
            framing_broken = 1'b1;
            r.error_raised = 1'b1;
          end else begin
            parsing_payload = 1'b1;
            bytes_remaining = size_acc;
            line_step       = (size_acc == '0) ? LINE_EXPECT_CR : LINE_BODY;
          end
          size_acc      = '0;
          digits_taken  = '0;
          bad_char_seen = 1'b0;
        end
      endcase
    end else begin
      case (line_step)
        LINE_BODY: begin
          if (bytes_remaining == '0) begin
            if (b != ChCr) begin
              framing_broken = 1'b1;
              r.error_raised = 1'b1;
            end else begin
              line_step = LINE_EXPECT_LF;
            end
          end else begin
            r.out_byte     = b;
            r.out_has_data = 1'b1;
            bytes_remaining--;
            if (bytes_remaining == '0) begin
              line_step = LINE_EXPECT_CR;
            end
          end
        end
        LINE_EXPECT_CR: begin
          if (b != ChCr) begin
            framing_broken = 1'b1;
            r.error_raised = 1'b1;
          end else begin
            line_step = LINE_EXPECT_LF;
          end
        end
        default: begin
          if (b != ChLf) begin
            framing_broken = 1'b1;
            r.error_raised = 1'b1;
          end else begin
            line_step       = LINE_BODY;
            parsing_payload = 1'b0;
            size_acc        = '0;
            digits_taken    = '0;
            bad_char_seen   = 1'b0;
          end
        end
      endcase
    end
    if (r.out_has_data || r.error_raised) begin
      decoded_queue.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cdec_result_t got;
    cdec_result_t want;
    if (!rst_ni) begin
      parsing_payload  = 1'b0;
      line_step        = LINE_BODY;
      size_acc         = '0;
      digits_taken     = '0;
      bad_char_seen    = 1'b0;
      bytes_remaining  = '0;
      framing_broken   = 1'b0;
      decoded_queue.delete();
      fail_count_o     = 0;
      pending_o        = 0;
      bytes_o          = 0;
      payload_o        = 0;
      raw_o            = 0;
      framing_errors_o = 0;
    end else begin
      // Results are compared before this edge's input is predicted.
      if (out_mon.valid && out_mon.ready) begin
        got.out_byte     = out_mon.out_byte;
        got.out_has_data = out_mon.out_has_data;
        got.error_raised = out_mon.error_raised;
        got.raw_mode     = out_mon.raw_mode;
        if (got.out_has_data && !got.raw_mode) payload_o++;
        if (got.raw_mode) raw_o++;
        if (got.error_raised) framing_errors_o++;
        if (decoded_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte=%02h data=%0b err=%0b raw=%0b",
                                    got.out_byte, got.out_has_data, got.error_raised,
                                    got.raw_mode));
        end else begin
          want = decoded_queue.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      got.out_byte, want.out_byte));
          if (got.out_has_data !== want.out_has_data)
            report_mismatch($sformatf("out_has_data %0b, expected %0b",
                                      got.out_has_data, want.out_has_data));
          if (got.error_raised !== want.error_raised)
            report_mismatch($sformatf("error_raised %0b, expected %0b",
                                      got.error_raised, want.error_raised));
          if (got.raw_mode !== want.raw_mode)
            report_mismatch($sformatf("raw_mode %0b, expected %0b",
                                      got.raw_mode, want.raw_mode));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        decode_byte(in_mon.in_byte);
        bytes_o++;
      end
      pending_o = decoded_queue.size();
    end
  end

endmodule

// File: test/chunked_transfer_decoder_core_tb.sv
// Top of the decoder testbench: clock, reset, chunked byte stimulus, pacing and verdict.
`timescale 1ns / 1ps
module chunked_transfer_decoder_core_tb;
  import cdec_pkg::*;

  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned RandomBytes = 1150;
  localparam int unsigned TailBytes   = 220;
  localparam int unsigned PaceSpan    = 90;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SRC_IDLE,
    PACE_SINK_STALL,
    PACE_BOTH
  } pace_e;

  typedef enum logic [2:0] {
    END_OVERLONG,
    END_BAD_DIGIT,
    END_EMPTY_SIZE,
    END_NO_CR,
    END_NO_LF,
    END_SATURATE
  } finale_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  cdec_in_if  in_if ();
  cdec_out_if out_if ();

  int fail_count;
  int pending;
  int bytes_seen;
  int payload_seen;
  int raw_seen;
  int framing_errors;

  pace_e      pace = PACE_FREE;
  finale_e    finale;
  logic [7:0] chunk_stream[$];
  int         quiet_cycles = 0;

  chunked_transfer_decoder_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cdec_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_if),
    .out_mon          (out_if),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .bytes_o          (bytes_seen),
    .payload_o        (payload_seen),
    .raw_o            (raw_seen),
    .framing_errors_o (framing_errors)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  // Pushes width hex characters of value, most significant first, without the line end.
  task automatic push_digits(input logic [35:0] value, input int width);
    for (int i = width - 1; i >= 0; i--) begin
      chunk_stream.push_back(hex_char(value[4*i +: 4]));
    end
  endtask

  task automatic push_crlf();
    chunk_stream.push_back(ChCr);
    chunk_stream.push_back(ChLf);
  endtask

  // Payload bytes are random, with line-end characters mixed in often.
  task automatic push_payload(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 15))
        0:       chunk_stream.push_back(ChCr);
        1:       chunk_stream.push_back(ChLf);
        default: chunk_stream.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic push_chunk(input int size, input int width);
    push_digits(36'(size), width);
    push_crlf();
    push_payload(size);
    if (size != 0 || $urandom_range(0, 1)) begin
      push_crlf();
    end else begin
      // A zero-size chunk still needs its closing line end.
      push_crlf();
    end
  endtask

  function automatic logic [7:0] not_this(input logic [7:0] avoid);
    logic [7:0] b;
    b = avoid;
    while (b == avoid) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = 8'h2F;
      1: b = 8'h3A;
      2: b = 8'h40;
      3: b = 8'h47;
      4: b = 8'h60;
      5: b = 8'h67;
      6: b = ChLf;
      default: begin
        b = ChCr;
        while (b == ChCr || (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66)) begin
          b = 8'($urandom_range(0, 255));
        end
      end
    endcase
    return b;
  endfunction

  task automatic build_stream();
    int size;
    int needed;
    int width;
    int len;
    int pos;
    // Directed opening: one byte, an empty chunk, and a size line of the longest legal length.
    push_chunk(1, 1);
    chunk_stream[3] = 8'hFF;
    push_chunk(0, 1);
    push_digits(36'h2, MaxSizeDigits);
    push_crlf();
    chunk_stream.push_back(8'h00);
    chunk_stream.push_back(8'h80);
    push_crlf();

    while (chunk_stream.size() < RandomBytes) begin
      case ($urandom_range(0, 99)) inside
        [0:7]:   size = 0;
        [8:79]:  size = $urandom_range(1, 16);
        [80:94]: size = $urandom_range(17, 64);
        default: size = $urandom_range(65, 300);
      endcase
      needed = 1;
      while ((size >> (4 * needed)) != 0) needed++;
      width = needed;
      // Leading zeros pad the size line up to the longest legal length at most.
      if ($urandom_range(0, 3) == 0) width = needed + $urandom_range(0, MaxSizeDigits - needed);
      push_chunk(size, width);
    end

    finale = finale_e'($urandom_range(0, 5));
    case (finale)
      END_OVERLONG: begin
        push_digits({4'($urandom), 32'($urandom)}, 9);
        chunk_stream.push_back($urandom_range(0, 1) ? ChCr : 8'($urandom_range(0, 255)));
      end
      END_BAD_DIGIT: begin
        len = $urandom_range(1, 8);
        pos = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
          chunk_stream.push_back(i == pos ? non_hex_char() : hex_char(4'($urandom)));
        end
        push_crlf();
      end
      END_EMPTY_SIZE: push_crlf();
      END_NO_CR: begin
        size = $urandom_range(0, 5);
        push_digits(36'(size), 1);
        push_crlf();
        push_payload(size);
        chunk_stream.push_back(not_this(ChCr));
      end
      END_NO_LF: begin
        if ($urandom_range(0, 1)) begin
          push_digits(36'h3, 1);
          chunk_stream.push_back(ChCr);
        end else begin
          push_digits(36'h2, 1);
          push_crlf();
          push_payload(2);
          chunk_stream.push_back(ChCr);
        end
        chunk_stream.push_back(not_this(ChLf));
      end
      default: begin
        // Nine digits with a nonzero lead saturate the size; the CR after them is overlong.
        push_digits({4'($urandom_range(1, 15)), 32'($urandom)}, 9);
        push_crlf();
      end
    endcase
    for (int i = 0; i < TailBytes; i++) begin
      chunk_stream.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic [7:0] b);
    while ((pace == PACE_SRC_IDLE && $urandom_range(0, 99) < 68) ||
           (pace == PACE_BOTH && $urandom_range(0, 99) < 24)) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= !((pace == PACE_SINK_STALL && $urandom_range(0, 99) < 68) ||
                        (pace == PACE_BOTH && $urandom_range(0, 99) < 24));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 QuietLimit, pending);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    build_stream();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < chunk_stream.size(); i++) begin
      case ((i / PaceSpan) % 5)
        1:       pace = PACE_SRC_IDLE;
        2:       pace = PACE_SINK_STALL;
        3:       pace = PACE_BOTH;
        default: pace = PACE_FREE;
      endcase
      send_byte(chunk_stream[i]);
    end
    in_if.valid <= 1'b0;
    pace = PACE_FREE;

    while (pending != 0) @(posedge clk_i);
    // Wait longer to catch any result the block should not have produced.
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes of chunked stream; checked %0d payload and %0d raw results.",
             bytes_seen, payload_seen, raw_seen);
    $display("Closing case %s, %0d framing error(s), across free, idle and stall pacing.",
             finale.name(), framing_errors);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cdec_pkg.sv
rtl/core/cdec_if.sv
rtl/core/cdec_parser.sv
rtl/core/cdec_queue.sv
rtl/core/chunked_transfer_decoder_core.sv
test/cdec_checker.sv
test/chunked_transfer_decoder_core_tb.sv
